/* design/mlk_pkg.sv */
// Shared types, constants and the Morse code table for the LED keyer.
`default_nettype none
package mlk_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned CharW = 8;
  localparam int unsigned PatW = 5;
  localparam int unsigned CntW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TabIdxW = 6;

  localparam logic [TickW-1:0] DotOnReset = 16'd800;
  localparam logic [TickW-1:0] DashOnReset = 16'd2000;
  localparam logic [TickW-1:0] GapReset = 16'd800;

  localparam logic [CfgIdxW-1:0] CfgDotOn = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDashOn = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGap = 2'd2;

  localparam logic CmdChar = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic [CharW-1:0] ChLf = 8'd10;
  localparam logic [CharW-1:0] ChCr = 8'd13;
  localparam logic [CharW-1:0] ChDigitLo = 8'd48;
  localparam logic [CharW-1:0] ChDigitHi = 8'd57;
  localparam logic [CharW-1:0] ChLowerLo = 8'd97;
  localparam logic [CharW-1:0] ChLowerHi = 8'd122;
  localparam logic [CharW-1:0] ChUpperLo = 8'd65;
  localparam logic [CharW-1:0] ChUpperHi = 8'd90;
  localparam logic [CharW-1:0] LowerBase = 8'd87;
  localparam logic [CharW-1:0] UpperBase = 8'd55;

  typedef struct packed {
    logic             cmd;
    logic [CharW-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic symbol_is_dash;
    logic char_rejected;
    logic line_end;
  } out_item_t;

  typedef struct packed {
    logic            is_eol;
    logic            is_known;
    logic [CntW-1:0] count;
    logic [PatW-1:0] pattern;
  } char_info_t;

  // Entry: count in [7:5], pattern in [4:0], 1 = dot, sent from the top symbol down.
  function automatic logic [CharW-1:0] morse_entry(input logic [TabIdxW-1:0] idx);
    logic [CharW-1:0] e;
    case (idx)
      6'd0: e = 8'd160;
      6'd1: e = 8'd176;
      6'd2: e = 8'd184;
      6'd3: e = 8'd188;
      6'd4: e = 8'd190;
      6'd5: e = 8'd191;
      6'd6: e = 8'd175;
      6'd7: e = 8'd167;
      6'd8: e = 8'd163;
      6'd9: e = 8'd161;
      6'd10: e = 8'd66;
      6'd11: e = 8'd135;
      6'd12: e = 8'd133;
      6'd13: e = 8'd99;
      6'd14: e = 8'd33;
      6'd15: e = 8'd141;
      6'd16: e = 8'd97;
      6'd17: e = 8'd143;
      6'd18: e = 8'd67;
      6'd19: e = 8'd136;
      6'd20: e = 8'd98;
      6'd21: e = 8'd139;
      6'd22: e = 8'd64;
      6'd23: e = 8'd65;
      6'd24: e = 8'd96;
      6'd25: e = 8'd137;
      6'd26: e = 8'd130;
      6'd27: e = 8'd101;
      6'd28: e = 8'd103;
      6'd29: e = 8'd32;
      6'd30: e = 8'd102;
      6'd31: e = 8'd142;
      6'd32: e = 8'd100;
      6'd33: e = 8'd134;
      6'd34: e = 8'd132;
      6'd35: e = 8'd131;
      default: e = 8'd0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

/* design/mlk_char_decode.sv */
// Character classifier: line end, digit/letter table lookup.
`default_nettype none
module mlk_char_decode (
  input  wire logic [mlk_pkg::CharW-1:0] char_code_i,
  output mlk_pkg::char_info_t            info_o
);

  logic                         is_digit;
  logic                         is_lower;
  logic                         is_upper;
  logic [mlk_pkg::TabIdxW-1:0]  off;
  logic [mlk_pkg::CharW-1:0]    entry;

  always_comb begin
    is_digit = (char_code_i >= mlk_pkg::ChDigitLo) && (char_code_i <= mlk_pkg::ChDigitHi);
    is_lower = (char_code_i >= mlk_pkg::ChLowerLo) && (char_code_i <= mlk_pkg::ChLowerHi);
    is_upper = (char_code_i >= mlk_pkg::ChUpperLo) && (char_code_i <= mlk_pkg::ChUpperHi);
    // Table offsets stay below 64, so the low bits of the difference suffice
    if (is_digit) begin
      off = char_code_i[mlk_pkg::TabIdxW-1:0] - mlk_pkg::ChDigitLo[mlk_pkg::TabIdxW-1:0];
    end else if (is_lower) begin
      off = char_code_i[mlk_pkg::TabIdxW-1:0] - mlk_pkg::LowerBase[mlk_pkg::TabIdxW-1:0];
    end else begin
      off = char_code_i[mlk_pkg::TabIdxW-1:0] - mlk_pkg::UpperBase[mlk_pkg::TabIdxW-1:0];
    end
    entry = mlk_pkg::morse_entry(off);
    info_o.is_eol   = (char_code_i == mlk_pkg::ChLf) || (char_code_i == mlk_pkg::ChCr);
    info_o.is_known = is_digit || is_lower || is_upper;
    info_o.count    = entry[mlk_pkg::CharW-1:mlk_pkg::PatW];
    info_o.pattern  = entry[mlk_pkg::PatW-1:0];
  end

endmodule
`default_nettype wire

/* design/morse_led_keyer_core.sv */
// Top level of the Morse LED keyer: symbol timing state, config registers, output buffer.
`default_nettype none
// Each item is a character or a one-millisecond tick and yields exactly one result item.
// The block takes one item per clock cycle: the keyer state updates when an item is accepted,
// and the result goes to an output register backed by one skid entry, so in_stall_o
// rises only when both hold results the consumer has not yet taken. Characters that
// arrive while a character is still being keyed are rejected. Timing registers are
// written through the cfg port, which is always ready.
module morse_led_keyer_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire mlk_pkg::in_item_t               in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output mlk_pkg::out_item_t                   out_item_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mlk_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [mlk_pkg::TickW-1:0]       cfg_data_i
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhOn   = 2'd1,
    PhGap  = 2'd2
  } phase_e;

  logic [mlk_pkg::TickW-1:0] dot_on_q, dash_on_q, gap_q;

  phase_e                    phase_q, phase_d;
  logic [mlk_pkg::PatW-1:0]  pat_q, pat_d;
  logic [mlk_pkg::CntW-1:0]  left_q, left_d;
  logic [mlk_pkg::TickW-1:0] cnt_q, cnt_d;

  logic                      out_valid_q, skid_valid_q;
  mlk_pkg::out_item_t        out_q, skid_q, res;

  mlk_pkg::char_info_t       info;
  logic                      accept;
  logic                      pop;
  logic                      busy_now;
  logic                      dash_now;
  logic                      busy_nxt;
  logic [mlk_pkg::TickW-1:0] cnt_inc;
  logic [mlk_pkg::TickW-1:0] on_limit;
  logic [mlk_pkg::CntW-1:0]  left_dec;

  function automatic logic sym_dash(input logic [mlk_pkg::PatW-1:0] pat,
                                    input logic [mlk_pkg::CntW-1:0] left);
    logic [mlk_pkg::CntW-1:0] bit_idx;
    logic                     d;
    bit_idx = left - 3'd1;
    if ((left == 3'd0) || (left > 3'd5)) begin
      d = 1'b0;
    end else begin
      d = ~pat[bit_idx];
    end
    return d;
  endfunction

  mlk_char_decode u_decode (
    .char_code_i (in_item_i.char_code),
    .info_o      (info)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign pop         = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    busy_now = (phase_q == PhOn) || (phase_q == PhGap);
    dash_now = sym_dash(pat_q, left_q);
    cnt_inc  = cnt_q + 16'd1;
    on_limit = dash_now ? dash_on_q : dot_on_q;
    left_dec = left_q - 3'd1;
    phase_d  = phase_q;
    pat_d    = pat_q;
    left_d   = left_q;
    cnt_d    = cnt_q;
    res      = '0;
    if (in_item_i.cmd == mlk_pkg::CmdTick) begin
      case (phase_q)
        PhOn: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= on_limit) begin
            phase_d = PhGap;
            cnt_d   = '0;
          end
        end
        PhGap: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= gap_q) begin
            cnt_d   = '0;
            left_d  = left_dec;
            phase_d = (left_dec == 3'd0) ? PhIdle : PhOn;
          end
        end
        default: ;
      endcase
    end else if (busy_now) begin
      res.char_rejected = 1'b1;
    end else if (info.is_eol) begin
      res.line_end = 1'b1;
    end else if (!info.is_known) begin
      res.char_rejected = 1'b1;
    end else begin
      pat_d   = info.pattern;
      left_d  = info.count;
      cnt_d   = '0;
      phase_d = (info.count == 3'd0) ? PhIdle : PhOn;
    end
    busy_nxt           = (phase_d == PhOn) || (phase_d == PhGap);
    res.led_on         = (phase_d == PhOn);
    res.busy_res       = busy_nxt;
    res.symbol_is_dash = busy_nxt && sym_dash(pat_d, left_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_on_q  <= mlk_pkg::DotOnReset;
      dash_on_q <= mlk_pkg::DashOnReset;
      gap_q     <= mlk_pkg::GapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mlk_pkg::CfgDotOn:  dot_on_q  <= cfg_data_i;
        mlk_pkg::CfgDashOn: dash_on_q <= cfg_data_i;
        mlk_pkg::CfgGap:    gap_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pat_q   <= '0;
      left_q  <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pat_q   <= pat_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_busy_has_symbols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PhOn) || (phase_q == PhGap)) |-> (left_q != 3'd0))
    else $error("keyer busy with no symbols left");

  a_busy_char_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_item_i.cmd == mlk_pkg::CmdChar) && busy_now)
      |=> ($stable(pat_q) && $stable(left_q) && $stable(cnt_q)))
    else $error("rejected character disturbed keying");

  a_led_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.led_on || out_q.busy_res))
    else $error("LED lit while not busy");

endmodule
`default_nettype wire
